### sv/epds_pkg.sv
// epds_pkg: types and constants shared by the event pixel decay shader
// holds the channel payload structs, register codes, pipeline stage structs
// and the reciprocal table for the series divide-by-k steps; no dependencies

package epds_pkg;

    // widths fixed by the item fields and registers
    localparam int unsigned TIME_W      = 64;
    localparam int unsigned PARAM_W     = 32;
    localparam int unsigned COLOR_W     = 24;
    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    // internal weight arithmetic is Q0.32
    localparam int unsigned Q_W   = 32;
    // integer part of age/param, cut off at 2^N_W
    localparam int unsigned N_W   = 5;
    localparam int unsigned REM_W = PARAM_W + N_W;

    localparam int unsigned SERIES_TERMS = 14;
    localparam int unsigned POW_STAGES   = (1 << N_W) - 1;

    // exp(-1) in Q0.32
    localparam logic [30:0] EXP_NEG_ONE_Q32 = 31'd1580030168;
    // 1.0 in Q1.32
    localparam logic [Q_W:0] Q_ONE = {1'b1, {Q_W{1'b0}}};

    // register reset values
    localparam logic [MODE_W-1:0]  DECAY_MODE_RST  = 2'd0;
    localparam logic [PARAM_W-1:0] DECAY_PARAM_RST = 32'd100000;
    localparam logic [COLOR_W-1:0] ON_COLOR_RST    = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] OFF_COLOR_RST   = 24'h000000;
    localparam logic [COLOR_W-1:0] IDLE_COLOR_RST  = 24'h808080;

    // floor(x/k) = (x * DIV_RECIP[k]) >> DIV_SHIFT[k], exact for 32-bit x
    localparam logic [Q_W:0] DIV_RECIP [1:SERIES_TERMS] = '{
        33'(((64'd1 << 32) + 64'd0)  / 64'd1),
        33'(((64'd1 << 33) + 64'd1)  / 64'd2),
        33'(((64'd1 << 34) + 64'd2)  / 64'd3),
        33'(((64'd1 << 34) + 64'd3)  / 64'd4),
        33'(((64'd1 << 35) + 64'd4)  / 64'd5),
        33'(((64'd1 << 35) + 64'd5)  / 64'd6),
        33'(((64'd1 << 35) + 64'd6)  / 64'd7),
        33'(((64'd1 << 35) + 64'd7)  / 64'd8),
        33'(((64'd1 << 36) + 64'd8)  / 64'd9),
        33'(((64'd1 << 36) + 64'd9)  / 64'd10),
        33'(((64'd1 << 36) + 64'd10) / 64'd11),
        33'(((64'd1 << 36) + 64'd11) / 64'd12),
        33'(((64'd1 << 36) + 64'd12) / 64'd13),
        33'(((64'd1 << 36) + 64'd13) / 64'd14)
    };
    localparam int unsigned DIV_SHIFT [1:SERIES_TERMS] = '{
        32, 33, 34, 34, 35, 35, 35, 35, 36, 36, 36, 36, 36, 36
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DECAY_MODE  = 3'd0,
        CFG_DECAY_PARAM = 3'd1,
        CFG_ON_COLOR    = 3'd2,
        CFG_OFF_COLOR   = 3'd3,
        CFG_IDLE_COLOR  = 3'd4
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_EXP    = 2'd0,
        MODE_LINEAR = 2'd1,
        MODE_WINDOW = 2'd2
    } decay_mode_t;

    // where the weight of an item finally comes from
    typedef enum logic [1:0] {
        LAM_ZERO = 2'd0,
        LAM_ONE  = 2'd1,
        LAM_FRAC = 2'd2,
        LAM_EXP  = 2'd3
    } lam_sel_t;

    typedef struct packed {
        logic [TIME_W-1:0] last_time;
        logic              has_event;
        logic              is_on;
        logic [TIME_W-1:0] frame_time;
    } pix_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    // age stage
    typedef struct packed {
        logic              valid;
        logic              is_on;
        logic              timed;
        logic              lam_one;
        logic [TIME_W-1:0] age;
    } age_t;

    // integer quotient stages
    typedef struct packed {
        logic             valid;
        logic             is_on;
        lam_sel_t         sel;
        logic [N_W-1:0]   n;
        logic [REM_W-1:0] rem;
    } qd_t;

    // fraction divider stages
    typedef struct packed {
        logic           valid;
        logic           is_on;
        lam_sel_t       sel;
        logic [N_W-1:0] n;
        logic [Q_W:0]   rem;
        logic [Q_W-1:0] quo;
    } fr_t;

    // exp series stages
    typedef struct packed {
        logic           valid;
        logic           is_on;
        lam_sel_t       sel;
        logic [N_W-1:0] n;
        logic [Q_W-1:0] f;
        logic [Q_W:0]   term;
        logic [Q_W:0]   sum;
    } ser_t;

    // exp(-1) power stages
    typedef struct packed {
        logic           valid;
        logic           is_on;
        logic [N_W-1:0] n;
        logic [Q_W:0]   v;
    } pw_t;

endpackage

### sv/event_pixel_decay_shader_core.sv
// event_pixel_decay_shader_core: time surface decay shader, one pixel per item
// computes a decay weight from the pixel age and blends idle toward on/off colour
// depends on epds_pkg
//
//  channel  side  handshake              payload
//  pix      in    pix_valid / pix_stall  pix_t: last_time, has_event, is_on, frame_time
//  rgb      out   rgb_valid / rgb_stall  rgb_t: red, green, blue
//  cfg      in    cfg_valid / cfg_ready  cfg_index (3 bits), cfg_data (32 bits)
//
// one item per clock while the skid is empty; rgb_valid rises after these registers:
// age stage, 6 quotient, 32 fraction divider (one bit each), 28 exp series
// (multiply then reciprocal divide per term), series close plus 31 exp(-1)
// products, then the blend into the output register
// reset clears every stage valid bit and loads the register defaults
// a stalled result parks in a skid register; the pipeline freezes only while
// the skid is full, so pix_stall is a plain register output

module event_pixel_decay_shader_core
    import epds_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   pix_valid,
    output logic                   pix_stall,
    input  pix_t                   pix,

    output logic                   rgb_valid,
    input  logic                   rgb_stall,
    output rgb_t                   rgb,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // weight in the blend is Q.F with 1.0 representable
    localparam int unsigned LAM_W = WEIGHT_FRAC_BITS + 1;
    localparam int unsigned ACC_W = WEIGHT_FRAC_BITS + CHAN_W + 1;
    localparam logic [LAM_W-1:0] WEIGHT_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

    // stage counts
    localparam int unsigned QD_STAGES  = N_W + 1;
    localparam int unsigned FR_STAGES  = Q_W;
    localparam int unsigned SER_STAGES = 2 * SERIES_TERMS;
    localparam int unsigned PW_STAGES  = POW_STAGES + 1;

    // ------------------------------------------------------------------
    // configuration registers, always ready
    // ------------------------------------------------------------------
    logic [MODE_W-1:0]  decay_mode_reg;
    logic [PARAM_W-1:0] decay_param_reg;
    logic [COLOR_W-1:0] on_color_reg;
    logic [COLOR_W-1:0] off_color_reg;
    logic [COLOR_W-1:0] idle_color_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_mode_reg  <= DECAY_MODE_RST;
            decay_param_reg <= DECAY_PARAM_RST;
            on_color_reg    <= ON_COLOR_RST;
            off_color_reg   <= OFF_COLOR_RST;
            idle_color_reg  <= IDLE_COLOR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DECAY_MODE:  decay_mode_reg  <= cfg_data[MODE_W-1:0];
                CFG_DECAY_PARAM: decay_param_reg <= cfg_data[PARAM_W-1:0];
                CFG_ON_COLOR:    on_color_reg    <= cfg_data[COLOR_W-1:0];
                CFG_OFF_COLOR:   off_color_reg   <= cfg_data[COLOR_W-1:0];
                CFG_IDLE_COLOR:  idle_color_reg  <= cfg_data[COLOR_W-1:0];
                default:         ;
            endcase
        end
    end

    // zero parameter behaves as one
    logic [PARAM_W-1:0] p_eff;
    logic [PARAM_W:0]   p_dbl;
    logic [PARAM_W:0]   frac_div;

    assign p_eff    = (decay_param_reg == '0) ? PARAM_W'(1) : decay_param_reg;
    assign p_dbl    = {p_eff, 1'b0};
    // linear mode divides by 2p, exponential by p
    assign frac_div = (decay_mode_reg == MODE_LINEAR) ? p_dbl : {1'b0, p_eff};

    // ------------------------------------------------------------------
    // stage functions
    // ------------------------------------------------------------------

    // classify by mode and range; sets up the remainder for the dividers
    function automatic qd_t classify(age_t a, logic [MODE_W-1:0] mode,
                                     logic [PARAM_W-1:0] p, logic [PARAM_W:0] p2);
        qd_t r;
        r.valid = a.valid;
        r.is_on = a.is_on;
        r.n     = '0;
        r.rem   = '0;
        r.sel   = a.lam_one ? LAM_ONE : LAM_ZERO;
        if (a.timed)
        begin
            case (mode)
                MODE_EXP:
                begin
                    // age/p of 32 or more decays to nothing
                    if (a.age >= TIME_W'({p, {N_W{1'b0}}}))
                    begin
                        r.sel = LAM_ZERO;
                    end
                    else
                    begin
                        r.sel = LAM_EXP;
                        r.rem = a.age[REM_W-1:0];
                    end
                end
                MODE_LINEAR:
                begin
                    if (a.age >= TIME_W'(p2))
                    begin
                        r.sel = LAM_ZERO;
                    end
                    else if (a.age == '0)
                    begin
                        r.sel = LAM_ONE;
                    end
                    else
                    begin
                        r.sel = LAM_FRAC;
                        r.rem = REM_W'(p2 - a.age[PARAM_W:0]);
                    end
                end
                MODE_WINDOW:
                begin
                    r.sel = (a.age < TIME_W'(p)) ? LAM_ONE : LAM_ZERO;
                end
                default:
                begin
                    r.sel = LAM_ZERO;
                end
            endcase
        end
        return r;
    endfunction

    // one bit of the integer quotient age/p
    function automatic qd_t qd_step(qd_t s, logic [REM_W-1:0] sub, logic [N_W-1:0] bitm);
        qd_t r;
        r = s;
        if (s.sel == LAM_EXP && s.rem >= sub)
        begin
            r.rem = s.rem - sub;
            r.n   = s.n | bitm;
        end
        return r;
    endfunction

    // one bit of the Q0.32 fraction rem/div, restoring
    function automatic fr_t fr_step(fr_t s, logic [Q_W:0] dv);
        fr_t          r;
        logic [Q_W+1:0] sh;
        logic         ge;
        r  = s;
        sh = {s.rem, 1'b0};
        ge = (sh >= {1'b0, dv});
        r.rem = ge ? (Q_W+1)'(sh - {1'b0, dv}) : sh[Q_W:0];
        r.quo = {s.quo[Q_W-2:0], ge};
        return r;
    endfunction

    // series term times f, and the previous term folded into the sum
    function automatic ser_t ser_mul(ser_t s, logic upd, logic sub);
        ser_t           r;
        logic [2*Q_W:0] prod;
        r    = s;
        prod = (2*Q_W+1)'(s.term) * (2*Q_W+1)'(s.f);
        r.term = prod[2*Q_W:Q_W];
        if (upd)
        begin
            r.sum = sub ? (s.sum - s.term) : (s.sum + s.term);
        end
        return r;
    endfunction

    // divide by k through its reciprocal
    function automatic ser_t ser_div(ser_t s, logic [Q_W:0] m, int unsigned sh);
        ser_t           r;
        logic [2*Q_W:0] prod;
        r    = s;
        prod = (2*Q_W+1)'(s.term[Q_W-1:0]) * (2*Q_W+1)'(m);
        r.term = (Q_W+1)'(prod >> sh);
        return r;
    endfunction

    // last series term, then the starting value for the power chain
    function automatic pw_t ser_final(ser_t s);
        pw_t          r;
        logic [Q_W:0] sum;
        sum     = s.sum + s.term;
        r.valid = s.valid;
        r.is_on = s.is_on;
        r.n     = '0;
        case (s.sel)
            LAM_ZERO: r.v = '0;
            LAM_ONE:  r.v = Q_ONE;
            LAM_FRAC: r.v = {1'b0, s.f};
            LAM_EXP:
            begin
                r.v = sum;
                r.n = s.n;
            end
            default:  r.v = '0;
        endcase
        return r;
    endfunction

    // one more factor of exp(-1) while the integer part asks for it
    function automatic pw_t pw_step(pw_t s, logic [N_W-1:0] idx);
        pw_t              r;
        logic [2*Q_W-1:0] prod;
        r    = s;
        prod = (2*Q_W)'(s.v) * (2*Q_W)'(EXP_NEG_ONE_Q32);
        if (s.n > idx)
        begin
            r.v = {1'b0, prod[2*Q_W-1:Q_W]};
        end
        return r;
    endfunction

    function automatic logic [CHAN_W-1:0] blend_chan(logic [LAM_W-1:0] lam,
                                                     logic [CHAN_W-1:0] idle,
                                                     logic [CHAN_W-1:0] tgt);
        logic [LAM_W-1:0] inv;
        logic [ACC_W-1:0] acc;
        inv = WEIGHT_ONE - lam;
        acc = ACC_W'(inv) * ACC_W'(idle) + ACC_W'(lam) * ACC_W'(tgt);
        return acc[WEIGHT_FRAC_BITS +: CHAN_W];
    endfunction

    // ------------------------------------------------------------------
    // pipeline
    // ------------------------------------------------------------------
    logic adv;

    age_t age_reg;
    age_t age_next;
    qd_t  qd_reg  [QD_STAGES];
    qd_t  qd_next [QD_STAGES];
    fr_t  fr_in;
    fr_t  fr_reg  [FR_STAGES];
    fr_t  fr_next [FR_STAGES];
    ser_t ser_in;
    ser_t ser_reg  [SER_STAGES];
    ser_t ser_next [SER_STAGES];
    pw_t  pw_reg  [PW_STAGES];
    pw_t  pw_next [PW_STAGES];

    // age and the two cases decided before any division
    always_comb
    begin
        age_next.valid   = pix_valid;
        age_next.is_on   = pix.is_on;
        age_next.age     = pix.frame_time - TIME_W'(1) - pix.last_time;
        age_next.timed   = pix.has_event && (pix.last_time < pix.frame_time);
        // age below zero gives full weight
        age_next.lam_one = pix.has_event;
    end

    assign qd_next[0] = classify(age_reg, decay_mode_reg, p_eff, p_dbl);

    for (genvar t = 1; t < QD_STAGES; t++)
    begin : gen_qd
        localparam int unsigned J = N_W - t;
        assign qd_next[t] = qd_step(qd_reg[t-1], REM_W'(p_eff) << J, N_W'(1) << J);
    end

    always_comb
    begin
        fr_in.valid = qd_reg[QD_STAGES-1].valid;
        fr_in.is_on = qd_reg[QD_STAGES-1].is_on;
        fr_in.sel   = qd_reg[QD_STAGES-1].sel;
        fr_in.n     = qd_reg[QD_STAGES-1].n;
        fr_in.rem   = qd_reg[QD_STAGES-1].rem[Q_W:0];
        fr_in.quo   = '0;
    end

    assign fr_next[0] = fr_step(fr_in, frac_div);

    for (genvar t = 1; t < FR_STAGES; t++)
    begin : gen_fr
        assign fr_next[t] = fr_step(fr_reg[t-1], frac_div);
    end

    always_comb
    begin
        ser_in.valid = fr_reg[FR_STAGES-1].valid;
        ser_in.is_on = fr_reg[FR_STAGES-1].is_on;
        ser_in.sel   = fr_reg[FR_STAGES-1].sel;
        ser_in.n     = fr_reg[FR_STAGES-1].n;
        ser_in.f     = fr_reg[FR_STAGES-1].quo;
        ser_in.term  = Q_ONE;
        ser_in.sum   = Q_ONE;
    end

    // term k: multiply stage then divide-by-k stage; odd terms subtract
    assign ser_next[0] = ser_mul(ser_in, 1'b0, 1'b0);
    assign ser_next[1] = ser_div(ser_reg[0], DIV_RECIP[1], DIV_SHIFT[1]);

    for (genvar k = 2; k <= SERIES_TERMS; k++)
    begin : gen_ser
        localparam logic PREV_ODD = ((k - 1) & 1) != 0;
        assign ser_next[2*k-2] = ser_mul(ser_reg[2*k-3], 1'b1, PREV_ODD);
        assign ser_next[2*k-1] = ser_div(ser_reg[2*k-2], DIV_RECIP[k], DIV_SHIFT[k]);
    end

    assign pw_next[0] = ser_final(ser_reg[SER_STAGES-1]);

    for (genvar i = 1; i < PW_STAGES; i++)
    begin : gen_pw
        assign pw_next[i] = pw_step(pw_reg[i-1], N_W'(i - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg.valid <= 1'b0;
            for (int t = 0; t < QD_STAGES; t++)
            begin
                qd_reg[t].valid <= 1'b0;
            end
            for (int t = 0; t < FR_STAGES; t++)
            begin
                fr_reg[t].valid <= 1'b0;
            end
            for (int t = 0; t < SER_STAGES; t++)
            begin
                ser_reg[t].valid <= 1'b0;
            end
            for (int t = 0; t < PW_STAGES; t++)
            begin
                pw_reg[t].valid <= 1'b0;
            end
        end
        else if (adv)
        begin
            age_reg <= age_next;
            qd_reg  <= qd_next;
            fr_reg  <= fr_next;
            ser_reg <= ser_next;
            pw_reg  <= pw_next;
        end
    end

    // ------------------------------------------------------------------
    // blend, output register and skid
    // ------------------------------------------------------------------
    logic [LAM_W-1:0]   lam;
    logic [COLOR_W-1:0] target;
    rgb_t               blend_rgb;

    // Q1.32 down to Q.F, truncated
    assign lam    = pw_reg[PW_STAGES-1].v[Q_W -: LAM_W];
    assign target = pw_reg[PW_STAGES-1].is_on ? on_color_reg : off_color_reg;

    always_comb
    begin
        blend_rgb.red   = blend_chan(lam, idle_color_reg[2*CHAN_W +: CHAN_W],
                                     target[2*CHAN_W +: CHAN_W]);
        blend_rgb.green = blend_chan(lam, idle_color_reg[CHAN_W +: CHAN_W],
                                     target[CHAN_W +: CHAN_W]);
        blend_rgb.blue  = blend_chan(lam, idle_color_reg[0 +: CHAN_W],
                                     target[0 +: CHAN_W]);
    end

    logic out_valid_reg;
    logic out_valid_next;
    rgb_t out_data_reg;
    rgb_t out_data_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    rgb_t skid_data_reg;
    rgb_t skid_data_next;
    logic out_free;

    // pipeline moves whenever the skid is empty
    assign adv       = !skid_valid_reg;
    assign pix_stall = skid_valid_reg;
    assign out_free  = !out_valid_reg || !rgb_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (out_free)
        begin
            out_valid_next = pw_reg[PW_STAGES-1].valid;
            out_data_next  = blend_rgb;
        end
        else if (pw_reg[PW_STAGES-1].valid)
        begin
            // output held, park the item leaving the pipeline
            skid_valid_next = 1'b1;
            skid_data_next  = blend_rgb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign rgb_valid = out_valid_reg;
    assign rgb       = out_data_reg;

endmodule

### tb/event_pixel_decay_shader_core_tb.sv
// event_pixel_decay_shader_core_tb: self-checking bench for the decay shader
// predicts each pixel colour from a local copy of the registers and checks every item
// depends on epds_pkg and event_pixel_decay_shader_core

module event_pixel_decay_shader_core_tb
    import epds_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WEIGHT_BITS = 16;

    // mode code that the block leaves undefined, weight forced to zero
    localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;

    // exponential mode gives up once the age reaches this many time constants
    localparam logic [63:0] EXP_CUTOFF = 64'd32;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   pix_valid = 1'b0;
    logic                   pix_stall;
    pix_t                   pix       = '0;

    logic                   rgb_valid;
    logic                   rgb_stall = 1'b0;
    rgb_t                   rgb;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // local copy of the registers, kept in step with every accepted write
    logic [MODE_W-1:0]  cur_mode  = DECAY_MODE_RST;
    logic [PARAM_W-1:0] cur_param = DECAY_PARAM_RST;
    logic [COLOR_W-1:0] cur_on    = ON_COLOR_RST;
    logic [COLOR_W-1:0] cur_off   = OFF_COLOR_RST;
    logic [COLOR_W-1:0] cur_idle  = IDLE_COLOR_RST;

    // colours still owed by the block, oldest first
    rgb_t pending_colours[$];
    int   mismatch_count = 0;

    // when set, neither side inserts gaps or stalls
    bit calm = 1'b0;

    event_pixel_decay_shader_core #(
        .WEIGHT_FRAC_BITS(WEIGHT_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb       (rgb),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // colour predictor
    // ------------------------------------------------------------------

    // exp(-f) for a Q0.32 fraction, alternating series with every term truncated
    function automatic logic [63:0] exp_series(input logic [63:0] f);
        logic [63:0] acc;
        logic [63:0] term;
        acc  = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int k = 1; k <= SERIES_TERMS; k++)
        begin
            term = ((term * f) >> 32) / 64'(k);
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return acc;
    endfunction

    // decay weight in Q0.WEIGHT_BITS for a non-negative age
    function automatic logic [63:0] decay_weight(input logic [63:0] age);
        logic [63:0] p;
        logic [63:0] whole;
        logic [63:0] rest;
        logic [63:0] v;
        logic [63:0] span;
        // a zero time constant behaves as one
        p = (cur_param == '0) ? 64'd1 : 64'(cur_param);
        case (cur_mode)
            MODE_EXP:
            begin
                whole = age / p;
                rest  = age % p;
                if (whole >= EXP_CUTOFF)
                    return 64'd0;
                v = exp_series((rest << 32) / p);
                for (int i = 0; i < int'(whole); i++)
                    v = (v * 64'(EXP_NEG_ONE_Q32)) >> 32;
                return v >> (32 - WEIGHT_BITS);
            end
            MODE_LINEAR:
            begin
                span = 64'd2 * p;
                if (age >= span)
                    return 64'd0;
                return ((span - age) << WEIGHT_BITS) / span;
            end
            MODE_WINDOW:
                return (age < p) ? (64'd1 << WEIGHT_BITS) : 64'd0;
            default:
                return 64'd0;
        endcase
    endfunction

    function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] idle,
                                                      input logic [CHAN_W-1:0] tgt,
                                                      input logic [63:0] lam);
        logic [63:0] acc;
        acc = ((64'd1 << WEIGHT_BITS) - lam) * 64'(idle) + lam * 64'(tgt);
        return CHAN_W'(acc >> WEIGHT_BITS);
    endfunction

    function automatic rgb_t shade_pixel(input pix_t p);
        logic [COLOR_W-1:0] tgt;
        logic [63:0]        lam;
        rgb_t               o;
        tgt = p.is_on ? cur_on : cur_off;
        if (!p.has_event)
            lam = 64'd0;
        else if (p.last_time >= p.frame_time)
            lam = 64'd1 << WEIGHT_BITS;          // event at or after the frame: full target
        else
            lam = decay_weight(p.frame_time - 64'd1 - p.last_time);
        o.red   = mix_channel(cur_idle[23:16], tgt[23:16], lam);
        o.green = mix_channel(cur_idle[15:8],  tgt[15:8],  lam);
        o.blue  = mix_channel(cur_idle[7:0],   tgt[7:0],   lam);
        return o;
    endfunction

    // ------------------------------------------------------------------
    // item generation
    // ------------------------------------------------------------------

    // pixel with an event of a given age, kept clear of timestamp wrap
    function automatic pix_t aged_pixel(input logic [63:0] age, input logic on);
        pix_t p;
        p.last_time  = {1'b0, 31'($urandom()), $urandom()};
        p.has_event  = 1'b1;
        p.is_on      = on;
        p.frame_time = p.last_time + 64'd1 + age;
        return p;
    endfunction

    // mostly ages spread around multiples of the time constant, some noise
    function automatic pix_t random_pixel();
        pix_t        p;
        logic [63:0] p64;
        logic [63:0] rest;
        logic [63:0] age;
        int unsigned kind;
        int unsigned whole;
        p64          = (cur_param == '0) ? 64'd1 : 64'(cur_param);
        kind         = $urandom_range(99);
        p.last_time  = {$urandom(), $urandom()};
        p.frame_time = {$urandom(), $urandom()};
        p.has_event  = 1'b1;
        p.is_on      = 1'($urandom_range(1));
        if (kind < 8)
            p.has_event = 1'b0;
        else if (kind < 16)
            p.last_time = p.frame_time + 64'($urandom_range(3));   // event not older than frame
        else if (kind >= 26)
        begin
            whole = ($urandom_range(1) == 0) ? $urandom_range(2) : $urandom_range(34);
            case ($urandom_range(3))
                0:       rest = 64'd0;
                1:       rest = p64 - 64'd1;
                default: rest = {$urandom(), $urandom()} % p64;
            endcase
            age          = 64'(whole) * p64 + rest;
            p.frame_time = p.last_time + 64'd1 + age;
        end
        return p;
    endfunction

    function automatic logic [COLOR_W-1:0] random_colour();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return COLOR_W'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    // present one pixel item, entered and left just after a rising edge
    task automatic send_pixel(input pix_t p);
        bit taken;
        while (!calm && $urandom_range(99) < 21)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        taken = 1'b0;
        while (!taken)
        begin
            // outputs are settled by the falling edge, so sample there
            @(negedge clk);
            taken = !pix_stall;
            if (taken)
                pending_colours.push_back(shade_pixel(p));
            @(posedge clk);
        end
    endtask

    // stop sending and let every owed colour come out
    task automatic wait_idle();
        pix_valid <= 1'b0;
        while (pending_colours.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DECAY_MODE:  cur_mode  = value[MODE_W-1:0];
            CFG_DECAY_PARAM: cur_param = value[PARAM_W-1:0];
            CFG_ON_COLOR:    cur_on    = value[COLOR_W-1:0];
            CFG_OFF_COLOR:   cur_off   = value[COLOR_W-1:0];
            CFG_IDLE_COLOR:  cur_idle  = value[COLOR_W-1:0];
            default:         ;
        endcase
        @(posedge clk);
    endtask

    // full register set, only ever with the pipeline drained
    task automatic configure(input logic [MODE_W-1:0] mode, input logic [PARAM_W-1:0] param,
                             input logic [COLOR_W-1:0] on, input logic [COLOR_W-1:0] off,
                             input logic [COLOR_W-1:0] idle);
        wait_idle();
        write_register(CFG_DECAY_MODE,  CFG_DATA_W'(mode));
        write_register(CFG_DECAY_PARAM, CFG_DATA_W'(param));
        write_register(CFG_ON_COLOR,    CFG_DATA_W'(on));
        write_register(CFG_OFF_COLOR,   CFG_DATA_W'(off));
        write_register(CFG_IDLE_COLOR,  CFG_DATA_W'(idle));
    endtask

    task automatic random_pixels(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(random_pixel());
    endtask

    // three time constants per mode: tiny, ordinary and the largest
    task automatic decay_sweep(input logic [MODE_W-1:0] mode, input int per_setting);
        logic [PARAM_W-1:0] param;
        for (int s = 0; s < 3; s++)
        begin
            case (s)
                0:       param = PARAM_W'($urandom_range(1, 64));
                1:       param = ($urandom_range(1) == 0) ? PARAM_W'($urandom())
                                                          : PARAM_W'($urandom_range(1, 1000000));
                default: param = '1;
            endcase
            configure(mode, param, random_colour(), random_colour(), random_colour());
            random_pixels(per_setting);
        end
    endtask

    // ------------------------------------------------------------------
    // result side: random stall and the checker
    // ------------------------------------------------------------------

    always @(posedge clk)
        rgb_stall <= !calm && ($urandom_range(99) < 21);

    // an item moves at the next rising edge when valid is up and stall is down
    always @(negedge clk)
    begin
        rgb_t want;
        if (rst_n && rgb_valid && !rgb_stall)
        begin
            if (pending_colours.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected colour r%0d g%0d b%0d", rgb.red, rgb.green, rgb.blue);
            end
            else
            begin
                want = pending_colours.pop_front();
                if (rgb.red !== want.red || rgb.green !== want.green || rgb.blue !== want.blue)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("colour mismatch: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                                 want.red, want.green, want.blue, rgb.red, rgb.green, rgb.blue);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // register defaults: exponential decay, constant 100000, white on black over grey
    task automatic test_reset_values();
        send_pixel('{last_time: 64'd5000, has_event: 1'b0, is_on: 1'b1, frame_time: 64'd9000});
        send_pixel('{last_time: 64'd7000, has_event: 1'b1, is_on: 1'b1, frame_time: 64'd7000});
        send_pixel('{last_time: 64'd7001, has_event: 1'b1, is_on: 1'b0, frame_time: 64'd7000});
        send_pixel('{last_time: '1, has_event: 1'b1, is_on: 1'b0, frame_time: '1});
        send_pixel('{last_time: '0, has_event: 1'b1, is_on: 1'b1, frame_time: '1});
        send_pixel(aged_pixel(64'd0, 1'b1));
        send_pixel(aged_pixel(64'd99999, 1'b1));
        send_pixel(aged_pixel(64'd100000, 1'b0));
        send_pixel(aged_pixel(64'd3199999, 1'b1));
        send_pixel(aged_pixel(64'd3200000, 1'b1));
    endtask

    // undefined mode, zero time constant in each mode, largest constant, colour extremes
    task automatic test_special_cases();
        configure(MODE_UNDEF, 32'd1000, '1, '0, IDLE_COLOR_RST);
        send_pixel(aged_pixel(64'd5, 1'b1));
        send_pixel(aged_pixel(64'd5, 1'b0));

        configure(MODE_EXP, '0, '1, '0, IDLE_COLOR_RST);
        send_pixel(aged_pixel(64'd0, 1'b1));
        send_pixel(aged_pixel(64'd31, 1'b1));

        configure(MODE_LINEAR, '0, '1, '0, IDLE_COLOR_RST);
        send_pixel(aged_pixel(64'd0, 1'b1));
        send_pixel(aged_pixel(64'd1, 1'b1));

        configure(MODE_WINDOW, '0, '1, '0, IDLE_COLOR_RST);
        send_pixel(aged_pixel(64'd0, 1'b1));
        send_pixel(aged_pixel(64'd1, 1'b0));

        // inverted palette, linear ramp at its very ends
        configure(MODE_LINEAR, '1, '0, '1, '1);
        send_pixel(aged_pixel(64'd0, 1'b1));
        send_pixel(aged_pixel(64'h1_FFFF_FFFB, 1'b0));

        // window edge on the largest constant
        configure(MODE_WINDOW, '1, '1, '0, '0);
        send_pixel(aged_pixel(64'hFFFF_FFFE, 1'b1));
        send_pixel(aged_pixel(64'hFFFF_FFFF, 1'b1));
    endtask

    task automatic test_exp_decay();
        decay_sweep(MODE_EXP, 117);
    endtask

    task automatic test_linear_decay();
        decay_sweep(MODE_LINEAR, 83);
    endtask

    task automatic test_window_decay();
        decay_sweep(MODE_WINDOW, 83);
    endtask

    task automatic test_undefined_mode();
        configure(MODE_UNDEF, PARAM_W'($urandom()), random_colour(), random_colour(),
                  random_colour());
        random_pixels(50);
    endtask

    // full rate on both sides for a long stretch
    task automatic test_back_to_back();
        for (int s = 0; s < 2; s++)
        begin
            configure(MODE_W'($urandom_range(2)), PARAM_W'($urandom_range(1, 5000)),
                      random_colour(), random_colour(), random_colour());
            calm = 1'b1;
            random_pixels(125);
            wait_idle();
            calm = 1'b0;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_special_cases();
        test_exp_decay();
        test_linear_decay();
        test_window_decay();
        test_undefined_mode();
        test_back_to_back();

        // drain, then allow a pipeline's worth of cycles for any stray result
        wait_idle();
        repeat (120) @(posedge clk);

        if (mismatch_count == 0 && pending_colours.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

### files.f
sv/epds_pkg.sv
sv/event_pixel_decay_shader_core.sv
tb/event_pixel_decay_shader_core_tb.sv
